// ===== src/llns_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package llns_pkg;

    localparam int ADDR_W  = 32;
    localparam int PORT_W  = 16;
    localparam int LOAD_W  = 10;
    localparam int AGE_W   = 8;
    localparam int WGT_W   = 4;
    localparam int PROD_W  = WGT_W + LOAD_W;
    localparam int SCORE_W = PROD_W + 1;

    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [LOAD_W-1:0] LOAD_MAX = 10'd1000;
    localparam logic [AGE_W-1:0]  AGE_MAX  = 8'hFF;

    localparam logic [AGE_W-1:0] TIMEOUT_RST    = 8'd5;
    localparam logic [WGT_W-1:0] CPU_WEIGHT_RST = 4'd6;
    localparam logic [WGT_W-1:0] RAM_WEIGHT_RST = 4'd4;

    typedef enum logic [1:0] {
        ACT_HEARTBEAT = 2'd0,
        ACT_TICK      = 2'd1,
        ACT_QUERY     = 2'd2,
        ACT_NONE      = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT    = 2'd0,
        CFG_CPU_WEIGHT = 2'd1,
        CFG_RAM_WEIGHT = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
        logic [LOAD_W-1:0] cpu;
        logic [LOAD_W-1:0] ram;
        logic [AGE_W-1:0]  age;
    } entry_t;

    typedef struct packed {
        logic start;
        logic issue;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic last_issue;
        logic out_free;
    } dp_sts_t;

    function automatic logic [LOAD_W-1:0] clamp_load(input logic [LOAD_W-1:0] v);
        return (v > LOAD_MAX) ? LOAD_MAX : v;
    endfunction

endpackage

`default_nettype wire

// ===== src/llns_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module llns_ctrl
    import llns_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    input  wire action_t s_action,
    input  wire dp_sts_t sts,
    output logic         s_tready,
    output dp_cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.start  = 1'b1;
                    state_next = (s_action == ACT_NONE) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.issue = 1'b1;
                if (sts.last_issue) begin
                    state_next = ST_DRAIN;
                end
            end
            // The last slot read returns and is processed here.
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/llns_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module llns_datapath
    import llns_pkg::*;
#(
    parameter int ENTRIES = 16,
    parameter int IW      = 4
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire dp_cmd_t           cmd,
    output dp_sts_t                sts,
    input  wire action_t           in_action,
    input  wire logic [ADDR_W-1:0] in_addr,
    input  wire logic [PORT_W-1:0] in_port,
    input  wire logic [LOAD_W-1:0] in_cpu,
    input  wire logic [LOAD_W-1:0] in_ram,
    input  wire logic [AGE_W-1:0]  timeout,
    input  wire logic [WGT_W-1:0]  cpu_w,
    input  wire logic [WGT_W-1:0]  ram_w,
    input  wire logic              m_tready,
    output logic                   m_tvalid,
    output logic                   out_success,
    output logic                   out_full,
    output logic [ADDR_W-1:0]      out_addr,
    output logic [PORT_W-1:0]      out_port
);

    entry_t mem [ENTRIES];

    // Request latched at acceptance.
    action_t           act_reg;
    logic [ADDR_W-1:0] key_addr_reg;
    logic [PORT_W-1:0] key_port_reg;
    logic [LOAD_W-1:0] cpu_reg;
    logic [LOAD_W-1:0] ram_reg;

    logic [IW-1:0]     issue_idx_reg;
    logic [IW-1:0]     rd_idx_reg;
    logic              rd_vld_reg;
    entry_t            rd_data_reg;

    logic [ENTRIES-1:0] valid_reg, valid_next;

    logic              hit_found_reg, hit_found_next;
    logic [IW-1:0]     hit_idx_reg, hit_idx_next;
    logic              free_found_reg, free_found_next;
    logic [IW-1:0]     free_idx_reg, free_idx_next;
    logic              best_found_reg, best_found_next;
    logic [SCORE_W-1:0] best_score_reg, best_score_next;
    logic [ADDR_W-1:0] best_addr_reg, best_addr_next;
    logic [PORT_W-1:0] best_port_reg, best_port_next;

    logic              m_tvalid_reg;
    logic              success_reg, full_reg;
    logic [ADDR_W-1:0] oaddr_reg;
    logic [PORT_W-1:0] oport_reg;

    logic              wr_en;
    logic [IW-1:0]     wr_idx;
    entry_t            wr_data;

    logic              slot_valid;
    logic              key_match;
    logic [PROD_W-1:0] prod_cpu, prod_ram;
    logic [SCORE_W-1:0] score;
    logic              hb_store;

    assign slot_valid = valid_reg[rd_idx_reg];
    assign key_match  = (rd_data_reg.addr == key_addr_reg) &&
                        (rd_data_reg.port == key_port_reg);
    assign prod_cpu   = PROD_W'(cpu_w) * PROD_W'(rd_data_reg.cpu);
    assign prod_ram   = PROD_W'(ram_w) * PROD_W'(rd_data_reg.ram);
    assign score      = SCORE_W'(prod_cpu) + SCORE_W'(prod_ram);
    assign hb_store   = hit_found_reg || free_found_reg;

    assign sts.last_issue = (issue_idx_reg == IW'(ENTRIES - 1));
    assign sts.out_free   = !m_tvalid_reg || m_tready;

    // Scan processing, one returned slot per cycle.
    always_comb begin
        valid_next      = valid_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        best_found_next = best_found_reg;
        best_score_next = best_score_reg;
        best_addr_next  = best_addr_reg;
        best_port_next  = best_port_reg;
        wr_en           = 1'b0;
        wr_idx          = rd_idx_reg;
        wr_data         = rd_data_reg;

        if (cmd.start) begin
            hit_found_next  = 1'b0;
            free_found_next = 1'b0;
            best_found_next = 1'b0;
        end else if (rd_vld_reg) begin
            case (act_reg)
                ACT_HEARTBEAT: begin
                    if (slot_valid) begin
                        if (!hit_found_reg && key_match) begin
                            hit_found_next = 1'b1;
                            hit_idx_next   = rd_idx_reg;
                        end
                    end else if (!free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = rd_idx_reg;
                    end
                end
                ACT_TICK: begin
                    if (slot_valid && rd_data_reg.age != AGE_MAX) begin
                        wr_en       = 1'b1;
                        wr_data.age = rd_data_reg.age + AGE_W'(1);
                    end
                end
                ACT_QUERY: begin
                    if (slot_valid) begin
                        if (rd_data_reg.age > timeout) begin
                            valid_next[rd_idx_reg] = 1'b0;
                        end else if (!best_found_reg || score < best_score_reg) begin
                            best_found_next = 1'b1;
                            best_score_next = score;
                            best_addr_next  = rd_data_reg.addr;
                            best_port_next  = rd_data_reg.port;
                        end
                    end
                end
                default: begin
                end
            endcase
        end else if (cmd.finish && act_reg == ACT_HEARTBEAT && hb_store) begin
            wr_en   = 1'b1;
            wr_idx  = hit_found_reg ? hit_idx_reg : free_idx_reg;
            wr_data = '{addr: key_addr_reg, port: key_port_reg,
                        cpu: cpu_reg, ram: ram_reg, age: '0};
            valid_next[wr_idx] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        if (cmd.issue) begin
            rd_data_reg <= mem[issue_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg     <= issue_idx_reg;
        hit_idx_reg    <= hit_idx_next;
        free_idx_reg   <= free_idx_next;
        best_score_reg <= best_score_next;
        best_addr_reg  <= best_addr_next;
        best_port_reg  <= best_port_next;
        if (cmd.start) begin
            act_reg      <= in_action;
            key_addr_reg <= in_addr;
            key_port_reg <= in_port;
            cpu_reg      <= clamp_load(in_cpu);
            ram_reg      <= clamp_load(in_ram);
        end
        if (cmd.finish) begin
            success_reg <= ((act_reg == ACT_HEARTBEAT) && hb_store) ||
                           ((act_reg == ACT_QUERY) && best_found_reg);
            full_reg    <= (act_reg == ACT_HEARTBEAT) && !hb_store;
            oaddr_reg   <= ((act_reg == ACT_QUERY) && best_found_reg) ? best_addr_reg : '0;
            oport_reg   <= ((act_reg == ACT_QUERY) && best_found_reg) ? best_port_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            issue_idx_reg  <= '0;
            rd_vld_reg     <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            valid_reg      <= valid_next;
            rd_vld_reg     <= cmd.issue;
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
            best_found_reg <= best_found_next;
            if (cmd.start) begin
                issue_idx_reg <= '0;
            end else if (cmd.issue) begin
                issue_idx_reg <= issue_idx_reg + IW'(1);
            end
            if (cmd.finish) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid    = m_tvalid_reg;
    assign out_success = success_reg;
    assign out_full    = full_reg;
    assign out_addr    = oaddr_reg;
    assign out_port    = oport_reg;

endmodule

`default_nettype wire

// ===== src/least_loaded_node_selector.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                    Payload
// s_        in         s_tvalid / s_tready          heartbeat, tick or query request
// m_        out        m_tvalid / m_tready          one result per request
// cfg_      in         cfg_valid / cfg_ready        register index and write data
//
// Each scan reads the single-port table one slot per cycle, then a drain step processes the last
// read and a finish step registers the result; an unused action skips the scan and drain steps.
// Synchronous active-low reset clears the slot valid bits, the controller and the
// registers to their defaults; there is no clearing pass over the memory.
// The next request is taken the cycle after a result issues, even while it waits on m_tready;
// only the step that hands over the following result waits for the output register to free.

module least_loaded_node_selector
    import llns_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // node_addr[31:0], node_port[47:32], cpu_load[57:48], ram_load[67:58], zero pad
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // action[1:0]
    input  wire logic [S_TUSER_W-1:0]  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // best_addr[31:0], best_port[47:32]
    output logic [M_TDATA_W-1:0]       m_tdata,
    // success[0], table_full[1]
    output logic [M_TUSER_W-1:0]       m_tuser,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [AGE_W-1:0] timeout_reg;
    logic [WGT_W-1:0] cpu_w_reg;
    logic [WGT_W-1:0] ram_w_reg;

    dp_cmd_t           cmd;
    dp_sts_t           sts;
    action_t           s_action;
    logic              out_success, out_full;
    logic [ADDR_W-1:0] out_addr;
    logic [PORT_W-1:0] out_port;

    assign s_action  = action_t'(s_tuser[1:0]);
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RST;
            cpu_w_reg   <= CPU_WEIGHT_RST;
            ram_w_reg   <= RAM_WEIGHT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_TIMEOUT:    timeout_reg <= cfg_data[AGE_W-1:0];
                CFG_CPU_WEIGHT: cpu_w_reg   <= cfg_data[WGT_W-1:0];
                CFG_RAM_WEIGHT: ram_w_reg   <= cfg_data[WGT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    llns_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_action (s_action),
        .sts      (sts),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    llns_datapath #(
        .ENTRIES (ENTRIES),
        .IW      (IW)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .in_action   (s_action),
        .in_addr     (s_tdata[31:0]),
        .in_port     (s_tdata[47:32]),
        .in_cpu      (s_tdata[57:48]),
        .in_ram      (s_tdata[67:58]),
        .timeout     (timeout_reg),
        .cpu_w       (cpu_w_reg),
        .ram_w       (ram_w_reg),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .out_success (out_success),
        .out_full    (out_full),
        .out_addr    (out_addr),
        .out_port    (out_port)
    );

    assign m_tdata = {out_port, out_addr};
    assign m_tuser = {out_full, out_success};

    // A request occupies the block, so the cycle after acceptance is never ready.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while previous one in progress");

    a_full_not_success: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("table_full and success both set");

    a_fail_zero_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("failed result carries a node address");

endmodule

`default_nettype wire

// ===== tb/tb_least_loaded_node_selector.sv =====
`timescale 1ns / 1ps

module tb_least_loaded_node_selector;
    import llns_pkg::*;

    localparam int ENTRIES     = 16;
    localparam int KEY_POOL    = 24;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 150;
    localparam int SAT_TICKS   = 300;
    localparam int STALL_LIMIT = 2000;

    // Index 3 has no register behind it; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic [AGE_W-1:0] PHASE_TIMEOUT [PHASES] = '{8'd5, 8'd0, 8'd255, 8'd2, 8'd255, 8'd3};
    localparam logic [WGT_W-1:0] PHASE_CPU_W [PHASES]   = '{4'd6, 4'd15, 4'd0, 4'd0, 4'd15, 4'd1};
    localparam logic [WGT_W-1:0] PHASE_RAM_W [PHASES]   = '{4'd4, 4'd0, 4'd15, 4'd0, 4'd15, 4'd9};

    typedef struct packed {
        logic              success;
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
        logic              full;
    } pick_t;

    class selector_scoreboard;
        logic              live [ENTRIES];
        logic [ADDR_W-1:0] node_addr [ENTRIES];
        logic [PORT_W-1:0] node_port [ENTRIES];
        logic [LOAD_W-1:0] node_cpu [ENTRIES];
        logic [LOAD_W-1:0] node_ram [ENTRIES];
        logic [AGE_W-1:0]  node_age [ENTRIES];
        logic [AGE_W-1:0]  timeout;
        logic [WGT_W-1:0]  w_cpu;
        logic [WGT_W-1:0]  w_ram;
        pick_t             pending_picks [$];
        int                errors;

        function new();
            foreach (live[i]) live[i] = 1'b0;
            timeout = TIMEOUT_RST;
            w_cpu   = CPU_WEIGHT_RST;
            w_ram   = RAM_WEIGHT_RST;
            errors  = 0;
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_TIMEOUT:    timeout = val;
                CFG_CPU_WEIGHT: w_cpu = val[WGT_W-1:0];
                CFG_RAM_WEIGHT: w_ram = val[WGT_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_request(action_t act, logic [ADDR_W-1:0] addr,
                                   logic [PORT_W-1:0] port, logic [LOAD_W-1:0] cpu,
                                   logic [LOAD_W-1:0] ram);
            pick_t res;
            int    hit;
            int    free_slot;
            int    best;
            int    score;
            int    best_score;
            res        = '0;
            hit        = -1;
            free_slot  = -1;
            best       = -1;
            best_score = 0;
            case (act)
                ACT_HEARTBEAT: begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (live[i]) begin
                            if (hit < 0 && node_addr[i] == addr && node_port[i] == port)
                                hit = i;
                        end else if (free_slot < 0) begin
                            free_slot = i;
                        end
                    end
                    if (hit < 0)
                        hit = free_slot;
                    if (hit >= 0) begin
                        live[hit]      = 1'b1;
                        node_addr[hit] = addr;
                        node_port[hit] = port;
                        node_cpu[hit]  = (cpu > LOAD_MAX) ? LOAD_MAX : cpu;
                        node_ram[hit]  = (ram > LOAD_MAX) ? LOAD_MAX : ram;
                        node_age[hit]  = '0;
                        res.success    = 1'b1;
                    end else begin
                        res.full = 1'b1;
                    end
                end
                ACT_TICK: begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (live[i] && node_age[i] != AGE_MAX)
                            node_age[i] = node_age[i] + AGE_W'(1);
                end
                ACT_QUERY: begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (live[i] && node_age[i] > timeout)
                            live[i] = 1'b0;
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (live[i]) begin
                            score = int'(w_cpu) * int'(node_cpu[i])
                                  + int'(w_ram) * int'(node_ram[i]);
                            if (best < 0 || score < best_score) begin
                                best       = i;
                                best_score = score;
                            end
                        end
                    end
                    if (best >= 0) begin
                        res.success = 1'b1;
                        res.addr    = node_addr[best];
                        res.port    = node_port[best];
                    end
                end
                default: ;
            endcase
            pending_picks.push_back(res);
        endfunction

        function void compare_field(string name, logic [ADDR_W-1:0] want,
                                    logic [ADDR_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser);
            pick_t want;
            if (pending_picks.size() == 0) begin
                $display("%0t: result with no request outstanding, expected none, actual %h/%b",
                         $time, tdata, tuser);
                errors++;
                return;
            end
            want = pending_picks.pop_front();
            compare_field("success", ADDR_W'(want.success), ADDR_W'(tuser[0]));
            compare_field("best_addr", want.addr, tdata[31:0]);
            compare_field("best_port", ADDR_W'(want.port), ADDR_W'(tdata[47:32]));
            compare_field("table_full", ADDR_W'(want.full), ADDR_W'(tuser[1]));
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int tx_idle_pct  = 12;
    int rx_idle_pct  = 86;
    int stall_cycles = 0;

    logic [ADDR_W-1:0] key_addr [KEY_POOL];
    logic [PORT_W-1:0] key_port [KEY_POOL];

    selector_scoreboard board = new();

    least_loaded_node_selector #(
        .ENTRIES(ENTRIES)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result(m_tdata, m_tuser);
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles = stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Leaves s_tvalid high after the handshake so back-to-back requests need no
    // second assignment in the same step; wait_for_results lowers it.
    task automatic send_request(input action_t act, input logic [ADDR_W-1:0] addr,
                                input logic [PORT_W-1:0] port, input logic [LOAD_W-1:0] cpu,
                                input logic [LOAD_W-1:0] ram);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= S_TDATA_W'({ram, cpu, port, addr});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_request(act, addr, port, cpu, ram);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending_picks.size() != 0) @(posedge aclk);
    endtask

    task automatic apply_settings(input logic [AGE_W-1:0] tmo, input logic [WGT_W-1:0] cw,
                                  input logic [WGT_W-1:0] rw);
        logic [CFG_IDX_W-1:0]  idx [4];
        logic [CFG_DATA_W-1:0] val [4];
        idx    = '{CFG_TIMEOUT, CFG_CPU_WEIGHT, CFG_RAM_WEIGHT, CFG_UNUSED};
        val[0] = tmo;
        // Upper bits of the weight writes carry noise that must be dropped.
        val[1] = CFG_DATA_W'($urandom());
        val[1][WGT_W-1:0] = cw;
        val[2] = CFG_DATA_W'($urandom());
        val[2][WGT_W-1:0] = rw;
        val[3] = CFG_DATA_W'($urandom());
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            board.note_config(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [LOAD_W-1:0] random_load();
        case ($urandom_range(5))
            0:       return '0;
            1:       return LOAD_MAX;
            2:       return LOAD_W'($urandom_range(1023, 1001));
            3:       return LOAD_W'($urandom_range(3));
            default: return LOAD_W'($urandom_range(1023));
        endcase
    endfunction

    // Heartbeats as the largest share, then ticks, queries and unused actions, from a pool of known
    // nodes, so entries get refreshed, age out and fill the table; a few come from never-seen nodes.
    task automatic send_random_request();
        int                pick;
        int                k;
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
        pick = $urandom_range(99);
        k    = $urandom_range(KEY_POOL - 1);
        addr = key_addr[k];
        port = key_port[k];
        if ($urandom_range(99) < 15) begin
            addr = $urandom();
            port = PORT_W'($urandom_range(16'hFFFF));
        end
        if (pick < 45)
            send_request(ACT_HEARTBEAT, addr, port, random_load(), random_load());
        else if (pick < 70)
            send_request(ACT_TICK, addr, port, random_load(), random_load());
        else if (pick < 95)
            send_request(ACT_QUERY, addr, port, random_load(), random_load());
        else
            send_request(ACT_NONE, addr, port, random_load(), random_load());
    endtask

    initial begin
        for (int i = 0; i < KEY_POOL; i++) begin
            // Every third node shares its address with the one before and
            // differs only in port.
            key_addr[i] = (i % 3 == 1) ? key_addr[i-1] : $urandom();
            key_port[i] = PORT_W'($urandom_range(16'hFFFF));
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed requests at the reset settings.
        send_request(ACT_QUERY, '1, '1, '1, '1);
        send_request(ACT_TICK, '1, '1, '1, '1);
        send_request(ACT_NONE, '1, '1, '1, '1);
        send_request(ACT_HEARTBEAT, '0, '0, '0, '0);
        send_request(ACT_HEARTBEAT, '1, '1, '1, '1);
        send_request(ACT_HEARTBEAT, 32'hC0A8_0001, 16'd8080, LOAD_MAX, '0);
        send_request(ACT_QUERY, '0, '0, '0, '0);
        send_request(ACT_HEARTBEAT, '0, '0, 10'd500, 10'd500);
        send_request(ACT_QUERY, '0, '0, '0, '0);
        for (int i = 0; i < ENTRIES - 3; i++)
            send_request(ACT_HEARTBEAT, 32'h0A00_0000 + i, 16'd9000, '0, '0);
        send_request(ACT_HEARTBEAT, 32'h0A00_00FF, 16'd9000, 10'd1, 10'd1);
        send_request(ACT_HEARTBEAT, '1, '1, 10'd3, 10'd2);
        send_request(ACT_QUERY, '1, '1, '1, '1);

        // Ages pin at their maximum: kept at the largest timeout, dropped at one less.
        wait_for_results();
        apply_settings(AGE_MAX, CPU_WEIGHT_RST, RAM_WEIGHT_RST);
        repeat (SAT_TICKS) send_request(ACT_TICK, $urandom(), '0, '0, '0);
        send_request(ACT_QUERY, $urandom(), '1, '0, '1);
        wait_for_results();
        apply_settings(AGE_MAX - AGE_W'(1), CPU_WEIGHT_RST, RAM_WEIGHT_RST);
        send_request(ACT_QUERY, $urandom(), '0, '1, '0);

        for (int p = 0; p < PHASES; p++) begin
            wait_for_results();
            case (p / 2)
                0: begin
                    tx_idle_pct = 12;
                    rx_idle_pct = 86;
                end
                1: begin
                    tx_idle_pct = 86;
                    rx_idle_pct = 12;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            apply_settings(PHASE_TIMEOUT[p], PHASE_CPU_W[p], PHASE_RAM_W[p]);
            repeat (PHASE_ITEMS) send_random_request();
        end

        wait_for_results();
        repeat (ENTRIES + 8) @(posedge aclk);
        if (board.errors == 0 && board.pending_picks.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
